/* sv/tird_pkg.sv */
// ---------------------------------------------------------------------------
// Tape image record deframer package
// Shared types and constants: header magic words, descriptor kinds, parser
// phases and the result descriptor that travels from the parser to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tird_pkg;

  // Widths of the descriptor fields
  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int IMG_LEN_W        = 32;
  localparam int OFS_W            = 32;
  localparam int LEN_W            = 24;
  localparam int BODY_W           = LEN_W + 1;
  localparam int WORD_W           = 32;
  localparam int QUEUE_DEPTH      = 4;

  // Header word codes
  localparam logic [WORD_W-1:0] MAGIC_EOM  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] MAGIC_MARK = 32'h0000_0000;
  localparam logic [WORD_W-1:0] MAGIC_GAP  = 32'hFFFF_FFFE;
  localparam logic [7:0]        CLASS_GOOD = 8'h00;
  localparam int                HDR_BYTES  = 4;

  typedef enum logic [2:0] {
    KIND_GOOD    = 3'd0,
    KIND_BAD     = 3'd1,
    KIND_MARK    = 3'd2,
    KIND_GAP     = 3'd3,
    KIND_EOM     = 3'd4,
    KIND_SUMMARY = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_TRAILER = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [OFS_W-1:0]  header_offset;
    logic [OFS_W-1:0]  flat_offset;
    logic [LEN_W-1:0]  record_length;
    logic              last;
  } result_t;

  // Up to two descriptors come out of one image byte
  typedef struct packed {
    logic    valid0;
    result_t res0;
    logic    valid1;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

/* sv/tird_parse.sv */
// ---------------------------------------------------------------------------
// Tape image parser
// Per-byte header, data and trailer tracking; produces the descriptors that
// one accepted image byte causes, in a single pass of logic.
// ---------------------------------------------------------------------------
`default_nettype none

module tird_parse #(
  parameter int OFFSET_WIDTH = tird_pkg::OFFSET_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            accept,
  input  wire  [7:0]                     image_byte,
  input  wire  [tird_pkg::IMG_LEN_W-1:0] image_length,
  output tird_pkg::push_t                push
);
  import tird_pkg::*;

  // Compare width: holds position + data + pad + trailer without overflow
  localparam int CW = ((OFFSET_WIDTH > IMG_LEN_W) ? OFFSET_WIDTH : IMG_LEN_W) + 2;

  phase_t                  phase, phase_next;
  logic [OFFSET_WIDTH-1:0] byte_position, byte_position_next;
  logic [WORD_W-1:0]       word_shift, word_shift_next;
  logic [1:0]              byte_in_word, byte_in_word_next;
  logic [WORD_W-1:0]       saved_header, saved_header_next;
  logic [BODY_W-1:0]       bytes_remaining, bytes_remaining_next;
  logic [OFFSET_WIDTH-1:0] record_start, record_start_next;
  logic [OFS_W-1:0]        flat_total, flat_total_next;

  logic [CW-1:0]     pos_ext, len_ext, start_ext, body_ext, next_ext;
  logic              active, step, word_done, overrun, trailer_match;
  logic [WORD_W-1:0] ws_shift;
  logic [LEN_W-1:0]  hdr_len, saved_len;
  logic [BODY_W-1:0] body, rem_dec;
  logic              rec_valid, sum_valid;
  result_t           rec, sum;

  // Shared decode of the current byte
  assign pos_ext   = {{(CW-OFFSET_WIDTH){1'b0}}, byte_position};
  assign len_ext   = {{(CW-IMG_LEN_W){1'b0}}, image_length};
  assign start_ext = {{(CW-OFFSET_WIDTH){1'b0}}, record_start};
  assign active    = pos_ext < len_ext;
  assign step      = accept && active;
  assign ws_shift  = {image_byte, word_shift[WORD_W-1:8]};
  assign word_done = (byte_in_word == 2'd3);
  assign hdr_len   = ws_shift[LEN_W-1:0];
  assign body      = {1'b0, hdr_len} + {{(BODY_W-1){1'b0}}, hdr_len[0]};
  assign body_ext  = {{(CW-BODY_W){1'b0}}, body};
  assign next_ext  = pos_ext + body_ext + CW'(1 + HDR_BYTES);
  assign overrun   = next_ext > len_ext;
  assign rem_dec   = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;
  assign saved_len = saved_header[LEN_W-1:0];
  assign trailer_match = (ws_shift == saved_header);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      case (phase)
        PH_HEADER: begin
          if (word_done && ws_shift != MAGIC_EOM && ws_shift != MAGIC_MARK &&
              ws_shift != MAGIC_GAP) begin
            if (overrun) begin
              phase_next = PH_STOPPED;
            end else if (body == '0) begin
              phase_next = PH_TRAILER;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (rem_dec == '0) begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          if (word_done) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Datapath state and descriptors
  always_comb begin
    byte_position_next   = byte_position;
    word_shift_next      = word_shift;
    byte_in_word_next    = byte_in_word;
    saved_header_next    = saved_header;
    bytes_remaining_next = bytes_remaining;
    record_start_next    = record_start;
    flat_total_next      = flat_total;
    rec_valid            = 1'b0;
    rec.kind             = KIND_MARK;
    rec.header_offset    = start_ext[OFS_W-1:0];
    rec.flat_offset      = flat_total;
    rec.record_length    = '0;
    rec.last             = 1'b1;
    sum_valid            = 1'b0;
    if (step) begin
      byte_position_next = byte_position + 1'b1;
      case (phase)
        PH_HEADER: begin
          if (byte_in_word == 2'd0) begin
            record_start_next = byte_position;
          end
          word_shift_next   = ws_shift;
          byte_in_word_next = byte_in_word + 2'd1;
          if (word_done) begin
            if (ws_shift == MAGIC_EOM) begin
              rec_valid = 1'b1;
              rec.kind  = KIND_EOM;
            end else if (ws_shift == MAGIC_MARK) begin
              rec_valid = 1'b1;
              rec.kind  = KIND_MARK;
            end else if (ws_shift == MAGIC_GAP) begin
              rec_valid = 1'b1;
              rec.kind  = KIND_GAP;
            end else if (!overrun) begin
              saved_header_next    = ws_shift;
              bytes_remaining_next = body;
            end
          end
        end
        PH_DATA: begin
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            byte_in_word_next = 2'd0;
          end
        end
        PH_TRAILER: begin
          word_shift_next   = ws_shift;
          byte_in_word_next = byte_in_word + 2'd1;
          if (word_done && trailer_match) begin
            rec_valid         = 1'b1;
            rec.kind          = (saved_header[WORD_W-1:LEN_W] == CLASS_GOOD) ?
                                KIND_GOOD : KIND_BAD;
            rec.record_length = saved_len;
            flat_total_next   = flat_total + {{(OFS_W-LEN_W){1'b0}}, saved_len};
          end
        end
        default: begin
          byte_position_next = byte_position + 1'b1;
        end
      endcase
      sum_valid = (pos_ext + CW'(1)) == len_ext;
    end
    rec.last          = !sum_valid;
    sum.kind          = KIND_SUMMARY;
    sum.header_offset = '0;
    sum.flat_offset   = flat_total_next;
    sum.record_length = '0;
    sum.last          = 1'b1;
  end

  // Order the descriptors of this byte: object first, summary after
  always_comb begin
    push.valid0 = rec_valid || sum_valid;
    push.res0   = rec_valid ? rec : sum;
    push.valid1 = rec_valid && sum_valid;
    push.res1   = sum;
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      word_shift      <= '0;
      byte_in_word    <= '0;
      saved_header    <= '0;
      bytes_remaining <= '0;
      record_start    <= '0;
      flat_total      <= '0;
    end else begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      word_shift      <= word_shift_next;
      byte_in_word    <= byte_in_word_next;
      saved_header    <= saved_header_next;
      bytes_remaining <= bytes_remaining_next;
      record_start    <= record_start_next;
      flat_total      <= flat_total_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tird_queue.sv */
// ---------------------------------------------------------------------------
// Result queue
// Small descriptor queue that takes up to two descriptors a cycle and hands
// out one per transfer; it decouples the parser from a stalling receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module tird_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire tird_pkg::push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tird_pkg::result_t      out_res
);
  import tird_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  result_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = slots[rd_ptr];
  // Accept a byte only while two descriptors still fit
  assign room      = (count <= CNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    count_next = count + {{(CNT_W-1){1'b0}}, push.valid0}
                       + {{(CNT_W-1){1'b0}}, push.valid1}
                       - {{(CNT_W-1){1'b0}}, pop};
  end

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      slots[wr_ptr] <= push.res0;
    end
    if (push.valid1) begin
      slots[wr_ptr + 1'b1] <= push.res1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {{(PTR_W-1){1'b0}}, push.valid0}
                       + {{(PTR_W-1){1'b0}}, push.valid1};
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tape_image_record_deframer.sv */
// ---------------------------------------------------------------------------
// Tape image record deframer
// Parses a byte stream of a tape image into object descriptors.
// ---------------------------------------------------------------------------
// Usage:
//   Write the image length in bytes on the cfg channel while the block is
//   idle, then stream the image on the s_ channel, one byte per transfer.
//   Each header word yields a descriptor for a mark, gap or end of medium;
//   a record yields one when its trailer matches the header. On the final
//   image byte an end summary with the total record data size follows.
//   Descriptors leave on the m_ channel; tlast flags the last descriptor
//   caused by one byte.
// Timing:
//   One byte per cycle while s_tready is high. A byte makes at most two
//   descriptors; they sit in a four-entry queue, and s_tready stays high
//   while two entries are free, so with the receiver always ready the
//   block takes a byte every cycle.
// Reset:
//   rst clears the parser, the length register and the queue.
// Stall:
//   When m_tready is low the queue fills and s_tready drops; nothing is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module tape_image_record_deframer #(
  parameter int OFFSET_WIDTH = tird_pkg::OFFSET_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // Configuration write
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data,     // image_length
  // Image bytes
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,      // [7:0] image_byte
  // Descriptors
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [87:0] m_tdata,      // [31:0] header_offset, [63:32] flat_offset,
                                    // [87:64] record_length
  output logic [2:0]  m_tuser,      // [2:0] item_kind
  output logic        m_tlast       // last_of_run
);
  import tird_pkg::*;

  logic [IMG_LEN_W-1:0] image_length;
  logic                 accept;
  push_t                push;
  result_t              out_res;

  // Hold the image length
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      image_length <= cfg_data;
    end
  end

  assign accept = s_tvalid && s_tready;

  tird_parse #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .image_byte   (s_tdata),
    .image_length (image_length),
    .push         (push)
  );

  tird_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the descriptor
  assign m_tdata = {out_res.record_length, out_res.flat_offset, out_res.header_offset};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

/* sv/tird_checker.sv */
// ---------------------------------------------------------------------------
// Tape image record deframer checker
// Port-level assertions on the descriptor channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tird_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [87:0] m_tdata,
  input wire [2:0]  m_tuser,
  input wire        m_tlast
);
  import tird_pkg::*;

  // A stalled descriptor stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("descriptor withdrawn while stalled");

  // A stalled descriptor keeps its contents
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("descriptor changed while stalled");

  // The summary always closes the run of its byte
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast)
    else $error("summary not flagged last");

  // Only records carry a length; the summary has no header offset
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_GOOD && m_tuser != KIND_BAD |->
      m_tdata[87:64] == '0 &&
      (m_tuser != KIND_SUMMARY || m_tdata[31:0] == '0))
    else $error("non-record descriptor carries length or offset");

endmodule

bind tape_image_record_deframer tird_checker u_tird_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* bench/tape_image_record_deframer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tape image record deframer testbench
// Streams tape images built from marks, gaps, end-of-medium words and good or
// bad records into the deframer and checks every descriptor it returns.
// A bit-accurate predictor computes the expected descriptors from each
// accepted byte. The stimulus covers broken trailers, header words cut short
// by the image end, bytes past the end, length changes mid-stream, an empty
// image and a record overrunning the image, under several idling patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module tape_image_record_deframer_tb;
  import tird_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 40;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = 32'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [87:0] m_tdata;     // [31:0] header_offset, [63:32] flat_offset,
                            // [87:64] record_length
  logic [2:0]  m_tuser;     // [2:0] item_kind
  logic        m_tlast;

  // Idling knobs, in percent
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // Predictor state
  logic [31:0] img_len;
  logic [31:0] img_pos;
  phase_t      parse_ph;
  logic [31:0] word_sr;
  logic [1:0]  word_cnt;
  logic [31:0] hdr_saved;
  logic [24:0] body_left;
  logic [31:0] obj_start;
  logic [31:0] flat_sum;

  result_t     expected_desc[$];
  logic [7:0]  image_q[$];
  logic [7:0]  carry_q[$];

  int err_count    = 0;
  int cycle_count  = 0;
  int n_bytes      = 0;
  int n_checked    = 0;
  int n_records    = 0;
  int n_summaries  = 0;
  int n_cfg        = 0;
  int random_bytes = 0;

  tape_image_record_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d descriptors outstanding",
               cycle_count, expected_desc.size());
      $display("** tape_image_record_deframer: FAILED **");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  function automatic result_t make_desc(input kind_t k, input logic [31:0] hdr,
                                        input logic [31:0] flat, input logic [23:0] len);
    result_t d;
    d.kind          = k;
    d.header_offset = hdr;
    d.flat_offset   = flat;
    d.record_length = len;
    d.last          = 1'b0;
    return d;
  endfunction

  function automatic void clear_model();
    img_len   = 32'd0;
    img_pos   = 32'd0;
    parse_ph  = PH_HEADER;
    word_sr   = 32'd0;
    word_cnt  = 2'd0;
    hdr_saved = 32'd0;
    body_left = 25'd0;
    obj_start = 32'd0;
    flat_sum  = 32'd0;
    expected_desc.delete();
  endfunction

  // Advance the parser by one image byte and queue the descriptors it causes
  function automatic void predict_descriptors(input logic [7:0] b);
    result_t     found[$];
    logic [31:0] w;
    logic [24:0] body;
    logic [63:0] obj_end;
    logic [31:0] p;
    p = img_pos;
    if (p >= img_len) return;
    case (parse_ph)
      PH_HEADER: begin
        if (word_cnt == 2'd0) obj_start = p;
        w        = {b, word_sr[31:8]};
        word_sr  = w;
        word_cnt = word_cnt + 2'd1;
        if (word_cnt == 2'd0) begin
          if (w == MAGIC_EOM) begin
            found.push_back(make_desc(KIND_EOM, obj_start, flat_sum, '0));
          end else if (w == MAGIC_MARK) begin
            found.push_back(make_desc(KIND_MARK, obj_start, flat_sum, '0));
          end else if (w == MAGIC_GAP) begin
            found.push_back(make_desc(KIND_GAP, obj_start, flat_sum, '0));
          end else begin
            // Data, pad and trailer must fit inside the image
            body    = {1'b0, w[23:0]} + {24'd0, w[0]};
            obj_end = {32'd0, p} + 64'd1 + {39'd0, body} + 64'(HDR_BYTES);
            if (obj_end > {32'd0, img_len}) begin
              parse_ph = PH_STOPPED;
            end else begin
              hdr_saved = w;
              body_left = body;
              parse_ph  = (body == '0) ? PH_TRAILER : PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (body_left != '0) body_left = body_left - 25'd1;
        if (body_left == '0) begin
          parse_ph = PH_TRAILER;
          word_cnt = 2'd0;
        end
      end
      PH_TRAILER: begin
        w        = {b, word_sr[31:8]};
        word_sr  = w;
        word_cnt = word_cnt + 2'd1;
        if (word_cnt == 2'd0) begin
          // A trailer that differs from the header drops the record
          if (w == hdr_saved) begin
            found.push_back(make_desc((hdr_saved[31:24] == CLASS_GOOD) ? KIND_GOOD : KIND_BAD,
                                      obj_start, flat_sum, hdr_saved[23:0]));
            flat_sum = flat_sum + {8'd0, hdr_saved[23:0]};
          end
          parse_ph = PH_HEADER;
        end
      end
      default: ;
    endcase
    img_pos = p + 32'd1;
    if ({1'b0, p} + 33'd1 == {1'b0, img_len})
      found.push_back(make_desc(KIND_SUMMARY, '0, flat_sum, '0));
    if (found.size() != 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_desc.push_back(found[i]);
  endfunction

  task automatic check_descriptor();
    result_t want;
    if (expected_desc.size() == 0) begin
      flag_error($sformatf("unexpected descriptor kind %0d header_offset %h",
                           m_tuser, m_tdata[31:0]));
      return;
    end
    want = expected_desc.pop_front();
    n_checked++;
    if (want.kind inside {KIND_GOOD, KIND_BAD}) n_records++;
    if (want.kind == KIND_SUMMARY) n_summaries++;
    if (m_tuser != want.kind)
      flag_error($sformatf("item_kind %0d, want %0d", m_tuser, want.kind));
    if (m_tdata[31:0] != want.header_offset)
      flag_error($sformatf("header_offset %h, want %h", m_tdata[31:0], want.header_offset));
    if (m_tdata[63:32] != want.flat_offset)
      flag_error($sformatf("flat_offset %h, want %h", m_tdata[63:32], want.flat_offset));
    if (m_tdata[87:64] != want.record_length)
      flag_error($sformatf("record_length %h, want %h", m_tdata[87:64], want.record_length));
    if (m_tlast != want.last)
      flag_error($sformatf("last_of_run %0b, want %0b", m_tlast, want.last));
  endtask

  // Track every transfer at the rising edge: predict first, then check
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        img_len = cfg_data;
        n_cfg++;
      end
      if (s_tvalid && s_tready) begin
        predict_descriptors(s_tdata);
        n_bytes++;
      end
      if (m_tvalid && m_tready) check_descriptor();
    end
  end

  // Drive one image byte; entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_image_bytes(input int count);
    repeat (count) send_byte(image_q.pop_front());
  endtask

  // Hold the sender until every expected descriptor has come, then drain
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (expected_desc.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_image_length(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_word(input logic [31:0] w);
    image_q.push_back(w[7:0]);
    image_q.push_back(w[15:8]);
    image_q.push_back(w[23:16]);
    image_q.push_back(w[31:24]);
  endtask

  // Record: header, data, pad on odd length, trailer (one bit flipped if broken)
  task automatic add_record(input logic [7:0] cls, input logic [23:0] len,
                            input bit trailer_ok);
    logic [31:0] hdr;
    hdr = {cls, len};
    add_word(hdr);
    repeat (len) image_q.push_back(8'($urandom_range(255)));
    if (len[0]) image_q.push_back(8'($urandom_range(255)));
    add_word(trailer_ok ? hdr : hdr ^ (32'd1 << $urandom_range(31)));
  endtask

  task automatic add_random_object();
    int unsigned sel;
    logic [7:0]  cls;
    logic [23:0] len;
    sel = $urandom_range(99);
    if (sel < 15) begin
      add_word(MAGIC_MARK);
    end else if (sel < 28) begin
      add_word(MAGIC_GAP);
    end else if (sel < 40) begin
      add_word(MAGIC_EOM);
    end else begin
      cls = ($urandom_range(99) < 65) ? CLASS_GOOD : 8'($urandom_range(255, 1));
      len = ($urandom_range(99) < 85) ? 24'($urandom_range(24)) : 24'($urandom_range(300));
      // A good record of length zero would read as a tape mark
      if (cls == CLASS_GOOD && len == '0) len = 24'd1;
      add_record(cls, len, $urandom_range(99) >= 12);
    end
  endtask

  // One image segment: optional open-ended length first, optional header
  // fragment at the end, optional bytes past the end
  task automatic run_chunk(input int target, input bit split, input bit fragment);
    int unsigned n0;
    int unsigned k;
    int unsigned cut;
    while (carry_q.size() != 0) image_q.push_back(carry_q.pop_front());
    while (image_q.size() < target) add_random_object();
    if (fragment) begin
      n0 = image_q.size();
      add_random_object();
      k = $urandom_range(3, 1);
      while (image_q.size() > n0 + k) carry_q.push_front(image_q.pop_back());
    end
    random_bytes += image_q.size();
    if (split && image_q.size() > 1) begin
      write_image_length(32'hFFFF_FFFF);
      cut = $urandom_range(image_q.size() - 1, 1);
      send_image_bytes(cut);
      settle_idle();
    end
    write_image_length(img_pos + 32'(image_q.size()));
    send_image_bytes(image_q.size());
    if ($urandom_range(99) < 25) repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    settle_idle();
  endtask

  task automatic test_empty_image();
    write_image_length(32'd0);
    repeat (3) send_byte(8'($urandom_range(255)));
    settle_idle();
  endtask

  // One of each descriptor kind; the last byte yields a record and the summary
  task automatic test_every_kind();
    add_word(MAGIC_MARK);
    add_word(MAGIC_GAP);
    add_word(MAGIC_EOM);
    add_record(8'hFF, 24'd0, 1'b1);
    add_record(CLASS_GOOD, 24'd1, 1'b1);
    write_image_length(img_pos + 32'(image_q.size()));
    send_image_bytes(image_q.size());
    send_byte(8'h00);
    send_byte(8'hFF);
    settle_idle();
  endtask

  task automatic test_length_change();
    run_chunk(40, 1'b1, 1'b1);
    run_chunk(30, 1'b1, 1'b0);
  endtask

  task automatic test_random_image(input int src, input int sink, input int budget);
    int base;
    int sent;
    src_idle_pct   = src;
    sink_stall_pct = sink;
    sent = 0;
    while (sent < budget) begin
      base = random_bytes;
      run_chunk($urandom_range(150, 20), $urandom_range(99) < 25, $urandom_range(99) < 30);
      sent += random_bytes - base;
    end
    if (carry_q.size() != 0) run_chunk(0, 1'b0, 1'b0);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Record of maximum length cannot fit: parsing stops, only the summary follows
  task automatic test_record_overrun();
    add_word({CLASS_GOOD, 24'hFF_FFFF});
    repeat (14) image_q.push_back(8'($urandom_range(255)));
    write_image_length(img_pos + 32'(image_q.size()));
    send_image_bytes(image_q.size());
    send_byte(8'($urandom_range(255)));
    settle_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_image();
    test_every_kind();
    test_length_change();
    test_random_image(0, 0, 400);
    test_random_image(87, 0, 400);
    test_random_image(0, 87, 400);
    test_random_image(11, 11, 400);
    test_record_overrun();

    settle_idle();
    repeat (16) @(posedge clk);
    if (expected_desc.size() != 0)
      flag_error($sformatf("%0d descriptors never arrived", expected_desc.size()));
    $display("Streamed %0d image bytes, checked %0d descriptors (%0d records, %0d summaries)",
             n_bytes, n_checked, n_records, n_summaries);
    $display("Wrote image_length %0d times; %0d mismatches", n_cfg, err_count);
    if (err_count == 0) begin
      $display("** tape_image_record_deframer: PASSED **");
    end else begin
      $display("** tape_image_record_deframer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
